FILE: sv/lsfb_pkg.sv
// ----------------------------------------------------------------------------
// lsfb_pkg
// shared constants and types of the led status frame builder
// ----------------------------------------------------------------------------
package lsfb_pkg;

	// number of pixels in the store (10 to 20)
	localparam int LED_COUNT = 10;
	localparam int IDX_W     = $clog2(LED_COUNT);

	// frame: two head bytes, rgb of each pixel, two tail bytes
	localparam int FRAME_LEN = 4 + 3 * LED_COUNT;
	localparam int POS_W     = $clog2(FRAME_LEN);

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// item kinds
	localparam logic [2:0] KIND_SET   = 3'd0;
	localparam logic [2:0] KIND_FILL  = 3'd1;
	localparam logic [2:0] KIND_CLEAR = 3'd2;
	localparam logic [2:0] KIND_TICK  = 3'd3;
	localparam logic [2:0] KIND_SEND  = 3'd4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic       remote_lost;
		logic       motor_lost;
		logic [1:0] chassis_mode;
		logic [1:0] gimbal_mode;
		logic [1:0] cap_mode;
	} status_t;

	// operations carried out by the back end
	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_TICK  = 2'd2,
		OP_SEND  = 2'd3
	} op_t;

	typedef struct packed {
		op_t     op;
		idx_t    lo;
		idx_t    hi;
		pixel_t  color;
		status_t status;
	} cmd_t;

endpackage

FILE: sv/led_status_frame_builder.sv
// ----------------------------------------------------------------------------
// led_status_frame_builder
// led pixel store with status rendering and framed byte output
// ----------------------------------------------------------------------------
// A set is a one-pixel fill. In the back end a fill walks its range pixel by
// pixel, a clear is done at its dispatch, and a period tick or send-now emits
// a frame of 4 + 3*LED_COUNT bytes (34 at ten pixels), one frame byte per
// cycle through the output register while the receiver takes them. The front
// end classifies each input word in the cycle it arrives and drops ignored
// ones (out-of-range sets and fills, empty fills, unused kinds); kept commands
// wait in a two-entry queue, so up to two kept words are taken while a frame
// is still going out. The tick counter advances only on an auto-rendered
// period tick. The auto_mode register is written through cfg_wen/cfg_wdata
// and resets to 1. No clearing pass is needed after reset: the store is
// cleared at once.
// ----------------------------------------------------------------------------
module led_status_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  first_index,
	input  logic [7:0]  last_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        remote_lost,
	input  logic [7:0]  motor_lost_mask,
	input  logic [1:0]  chassis_mode,
	input  logic [1:0]  gimbal_mode,
	input  logic [1:0]  cap_mode,
	// frame bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_last
);

	// front to queue
	logic            push;
	logic            q_full;
	lsfb_pkg::cmd_t  push_cmd;

	// queue to back
	logic            q_valid;
	logic            pop;
	lsfb_pkg::cmd_t  q_cmd;

	// classify words, drop ignored ones
	lsfb_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.first_index     (first_index),
		.last_index      (last_index),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.remote_lost     (remote_lost),
		.motor_lost_mask (motor_lost_mask),
		.chassis_mode    (chassis_mode),
		.gimbal_mode     (gimbal_mode),
		.cap_mode        (cap_mode),
		.q_full          (q_full),
		.push            (push),
		.cmd             (push_cmd)
	);

	// decouples the front from a busy back end
	lsfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_cmd),
		.valid  (q_valid)
	);

	// store, renderer and serializer
	lsfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

FILE: sv/lsfb_front.sv
// ----------------------------------------------------------------------------
// lsfb_front
// accepts input words, drops ignored ones and turns the rest into commands
// ----------------------------------------------------------------------------
module lsfb_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [7:0]        first_index,
	input  logic [7:0]        last_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              remote_lost,
	input  logic [7:0]        motor_lost_mask,
	input  logic [1:0]        chassis_mode,
	input  logic [1:0]        gimbal_mode,
	input  logic [1:0]        cap_mode,
	input  logic              q_full,
	output logic              push,
	output lsfb_pkg::cmd_t    cmd
);

	logic            first_ok;
	logic            keep;
	lsfb_pkg::idx_t  last_cl;

	assign first_ok = first_index < 8'(lsfb_pkg::LED_COUNT);
	assign last_cl  = (last_index < 8'(lsfb_pkg::LED_COUNT)) ?
		last_index[lsfb_pkg::IDX_W-1:0] : lsfb_pkg::IDX_W'(lsfb_pkg::LED_COUNT - 1);

	always_comb begin
		keep                    = 1'b0;
		cmd.op                  = lsfb_pkg::OP_SEND;
		cmd.lo                  = first_index[lsfb_pkg::IDX_W-1:0];
		cmd.hi                  = last_cl;
		cmd.color               = '{red: red, green: green, blue: blue};
		cmd.status.remote_lost  = remote_lost;
		cmd.status.motor_lost   = |motor_lost_mask;
		cmd.status.chassis_mode = chassis_mode;
		cmd.status.gimbal_mode  = gimbal_mode;
		cmd.status.cap_mode     = cap_mode;
		case (kind)
			lsfb_pkg::KIND_SET: begin
				// a set is a fill of one pixel
				keep   = first_ok;
				cmd.op = lsfb_pkg::OP_FILL;
				cmd.hi = first_index[lsfb_pkg::IDX_W-1:0];
			end
			lsfb_pkg::KIND_FILL: begin
				keep   = first_ok && (first_index[lsfb_pkg::IDX_W-1:0] <= last_cl);
				cmd.op = lsfb_pkg::OP_FILL;
			end
			lsfb_pkg::KIND_CLEAR: begin
				keep   = 1'b1;
				cmd.op = lsfb_pkg::OP_CLEAR;
			end
			lsfb_pkg::KIND_TICK: begin
				keep   = 1'b1;
				cmd.op = lsfb_pkg::OP_TICK;
			end
			lsfb_pkg::KIND_SEND: begin
				keep   = 1'b1;
				cmd.op = lsfb_pkg::OP_SEND;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped words are still taken from the channel
	assign in_ready = !q_full;
	assign push     = in_valid && keep && !q_full;

endmodule

FILE: sv/lsfb_queue.sv
// ----------------------------------------------------------------------------
// lsfb_queue
// short command fifo between the front and back ends
// ----------------------------------------------------------------------------
module lsfb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsfb_pkg::cmd_t  wdata,
	output logic            full,
	input  logic            pop,
	output lsfb_pkg::cmd_t  rdata,
	output logic            valid
);

	lsfb_pkg::cmd_t                 mem_q [lsfb_pkg::Q_DEPTH];
	logic [lsfb_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [lsfb_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [lsfb_pkg::Q_CNT_W-1:0]   count_q;

	function automatic logic [lsfb_pkg::Q_PTR_W-1:0] ptr_next(
		input logic [lsfb_pkg::Q_PTR_W-1:0] p);
		if (p == lsfb_pkg::Q_PTR_W'(lsfb_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full  = count_q == lsfb_pkg::Q_CNT_W'(lsfb_pkg::Q_DEPTH);
	assign valid = count_q != '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lsfb_pkg::Q_CNT_W'(lsfb_pkg::Q_DEPTH))
		else $error("command queue holds more than its depth");

endmodule

FILE: sv/lsfb_back.sv
// ----------------------------------------------------------------------------
// lsfb_back
// pixel store, status renderer and frame serializer
// ----------------------------------------------------------------------------
module lsfb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic            cfg_wdata,
	input  logic            q_valid,
	input  lsfb_pkg::cmd_t  q_cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      frame_byte,
	output logic            frame_last
);

	localparam logic [7:0] HEAD_A   = 8'hAA;
	localparam logic [7:0] HEAD_B   = 8'h55;
	localparam logic [7:0] LVL_DIM  = 8'd12;
	localparam logic [7:0] LVL_LOW  = 8'd24;
	localparam logic [7:0] LVL_MID  = 8'd48;
	localparam logic [7:0] LVL_HIGH = 8'd96;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FILL = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                       state_q;
	logic                         auto_mode_q;
	logic [7:0]                   tick_q;
	logic [1:0]                   tick_mod3_q;
	lsfb_pkg::pixel_t             store_q [lsfb_pkg::LED_COUNT];
	lsfb_pkg::idx_t               fill_idx_q;
	lsfb_pkg::idx_t               fill_hi_q;
	lsfb_pkg::pixel_t             color_q;
	logic [lsfb_pkg::POS_W-1:0]   pos_q;
	lsfb_pkg::idx_t               pix_q;
	logic [1:0]                   comp_q;
	logic                         out_valid_q;
	logic [7:0]                   frame_byte_q;
	logic                         frame_last_q;

	logic                         clear_go;
	logic                         render_go;
	logic                         emit_go;
	logic                         out_load;
	logic                         body;
	logic                         pos_end;
	logic [7:0]                   byte_d;
	lsfb_pkg::pixel_t             rd_pix;

	function automatic lsfb_pkg::pixel_t mk(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return '{red: r, green: g, blue: b};
	endfunction

	function automatic lsfb_pkg::pixel_t render_pixel(input lsfb_pkg::idx_t idx,
		input logic tick_odd, input logic [1:0] mod3, input lsfb_pkg::status_t st);
		lsfb_pkg::pixel_t p;
		p = mk(8'd0, 8'd0, 8'd0);
		if (st.remote_lost) begin
			if (!tick_odd) begin
				p = mk(LVL_HIGH, 8'd0, 8'd0);
			end
		end else if (idx inside {lsfb_pkg::IDX_W'(0), lsfb_pkg::IDX_W'(1),
			lsfb_pkg::IDX_W'(2)}) begin
			p = st.motor_lost ? mk(LVL_MID, LVL_LOW, 8'd0) : mk(8'd0, LVL_MID, 8'd0);
		end else if (idx inside {lsfb_pkg::IDX_W'(3), lsfb_pkg::IDX_W'(4),
			lsfb_pkg::IDX_W'(5)}) begin
			case (st.chassis_mode)
				2'd0: p = mk(8'd0, 8'd0, LVL_DIM);
				2'd1: p = mk(8'd0, LVL_MID, LVL_MID);
				2'd2: begin
					// spin: one marker walks over the three pixels
					if (idx == lsfb_pkg::IDX_W'(3) + lsfb_pkg::IDX_W'(mod3)) begin
						p = mk(LVL_HIGH, 8'd0, LVL_HIGH);
					end else begin
						p = mk(LVL_LOW, 8'd0, LVL_MID);
					end
				end
				default: p = mk(LVL_MID, LVL_MID, 8'd0);
			endcase
		end else if (idx == lsfb_pkg::IDX_W'(6)) begin
			case (st.gimbal_mode)
				2'd0:    p = mk(LVL_LOW, 8'd0, 8'd0);
				2'd1:    p = mk(LVL_MID, LVL_MID, 8'd0);
				2'd2:    p = mk(LVL_LOW, 8'd0, LVL_MID);
				default: p = mk(8'd0, LVL_MID, 8'd0);
			endcase
		end else if (idx == lsfb_pkg::IDX_W'(7)) begin
			case (st.cap_mode)
				2'd2:    p = mk(8'd0, 8'd0, LVL_HIGH);
				2'd1:    p = mk(8'd0, LVL_MID, 8'd0);
				default: p = mk(LVL_MID, LVL_LOW, 8'd0);
			endcase
		end else if (idx == lsfb_pkg::IDX_W'(8)) begin
			if (!tick_odd) begin
				p = mk(LVL_LOW, LVL_LOW, LVL_LOW);
			end
		end else if (idx == lsfb_pkg::IDX_W'(9)) begin
			if (tick_odd) begin
				p = mk(LVL_LOW, LVL_LOW, LVL_LOW);
			end
		end
		return p;
	endfunction

	// dispatch from the queue only while idle
	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign clear_go  = pop && (q_cmd.op == lsfb_pkg::OP_CLEAR);
	assign render_go = pop && (q_cmd.op == lsfb_pkg::OP_TICK) && auto_mode_q;
	assign emit_go   = pop && ((q_cmd.op == lsfb_pkg::OP_TICK) ||
		(q_cmd.op == lsfb_pkg::OP_SEND));

	// frame byte selection
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign pos_end  = pos_q == lsfb_pkg::POS_W'(lsfb_pkg::FRAME_LEN - 1);
	assign body     = (pos_q >= lsfb_pkg::POS_W'(2)) &&
		(pos_q < lsfb_pkg::POS_W'(lsfb_pkg::FRAME_LEN - 2));
	assign rd_pix   = store_q[pix_q];

	always_comb begin
		if (pos_q == lsfb_pkg::POS_W'(0)) begin
			byte_d = HEAD_A;
		end else if (pos_q == lsfb_pkg::POS_W'(1)) begin
			byte_d = HEAD_B;
		end else if (pos_q == lsfb_pkg::POS_W'(lsfb_pkg::FRAME_LEN - 2)) begin
			byte_d = HEAD_B;
		end else if (pos_end) begin
			byte_d = HEAD_A;
		end else begin
			case (comp_q)
				2'd0:    byte_d = rd_pix.red;
				2'd1:    byte_d = rd_pix.green;
				default: byte_d = rd_pix.blue;
			endcase
		end
	end

	// pixel store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsfb_pkg::LED_COUNT; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < lsfb_pkg::LED_COUNT; i++) begin
				if (clear_go) begin
					store_q[i] <= '0;
				end else if (render_go) begin
					store_q[i] <= render_pixel(lsfb_pkg::IDX_W'(i), tick_q[0],
						tick_mod3_q, q_cmd.status);
				end else if ((state_q == ST_FILL) &&
					(fill_idx_q == lsfb_pkg::IDX_W'(i))) begin
					store_q[i] <= color_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (q_cmd.op == lsfb_pkg::OP_FILL)) begin
			fill_hi_q <= q_cmd.hi;
			color_q   <= q_cmd.color;
		end
		if (out_load) begin
			frame_byte_q <= byte_d;
			frame_last_q <= pos_end;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			auto_mode_q <= 1'b1;
			tick_q      <= '0;
			tick_mod3_q <= '0;
			fill_idx_q  <= '0;
			pos_q       <= '0;
			pix_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				auto_mode_q <= cfg_wdata;
			end
			if (render_go) begin
				tick_q      <= tick_q + 1'b1;
				// restarts with the counter when it wraps to zero
				tick_mod3_q <= ((tick_mod3_q == 2'd2) || (tick_q == 8'hFF)) ?
					2'd0 : tick_mod3_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (q_cmd.op == lsfb_pkg::OP_FILL)) begin
						fill_idx_q <= q_cmd.lo;
						state_q    <= ST_FILL;
					end else if (emit_go) begin
						pos_q   <= '0;
						pix_q   <= '0;
						comp_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_FILL: begin
					if (fill_idx_q == fill_hi_q) begin
						state_q <= ST_IDLE;
					end else begin
						fill_idx_q <= fill_idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						pos_q <= pos_q + 1'b1;
						if (body) begin
							if (comp_q == 2'd2) begin
								comp_q <= 2'd0;
								pix_q  <= pix_q + 1'b1;
							end else begin
								comp_q <= comp_q + 1'b1;
							end
						end
						if (pos_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_last = frame_last_q;

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fill_idx_q <= fill_hi_q))
		else $error("fill walked past its last pixel");

	a_frame_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && pos_end) |=> (state_q == ST_IDLE))
		else $error("back end did not return to idle after the tail byte");

	a_tick_on_render: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> $past(render_go))
		else $error("tick counter moved without a render");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// led_status_frame_builder testbench
// drives set, fill, clear, period tick and send-now words under random
// handshake idling, predicts every frame byte from a shadow pixel store and
// tick counter, and checks the byte stream field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	// unused kind codes, dropped by the block
	localparam logic [2:0] KIND_SPARE5 = 3'd5;
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	// status codes
	localparam logic [1:0] CH_NO_MOVE   = 2'd0;
	localparam logic [1:0] CH_FOLLOW    = 2'd1;
	localparam logic [1:0] CH_SPIN      = 2'd2;
	localparam logic [1:0] CH_RETURN    = 2'd3;
	localparam logic [1:0] GM_ZERO      = 2'd0;
	localparam logic [1:0] GM_INIT      = 2'd1;
	localparam logic [1:0] GM_SPIN      = 2'd2;
	localparam logic [1:0] GM_ANGLE     = 2'd3;
	localparam logic [1:0] CAP_CHARGING = 2'd0;
	localparam logic [1:0] CAP_PREPARED = 2'd1;
	localparam logic [1:0] CAP_IN_USE   = 2'd2;
	localparam logic [1:0] CAP_UNUSED   = 2'd3;

	// frame markers and render levels
	localparam logic [7:0] HEAD_A   = 8'hAA;
	localparam logic [7:0] HEAD_B   = 8'h55;
	localparam logic [7:0] LVL_DIM  = 8'd12;
	localparam logic [7:0] LVL_LOW  = 8'd24;
	localparam logic [7:0] LVL_MID  = 8'd48;
	localparam logic [7:0] LVL_HIGH = 8'd96;

	localparam lsfb_pkg::pixel_t BLACK = '0;
	localparam lsfb_pkg::pixel_t WHITE = '{8'hFF, 8'hFF, 8'hFF};
	localparam lsfb_pkg::pixel_t ALARM = '{LVL_HIGH, 8'h00, 8'h00};

	// quiet cycles before a register write and at the end of the run
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 39;
	localparam int DIR_ROWS      = 28;
	localparam int TIMEOUT_NS    = 8_000_000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] first_index;
		logic [7:0] last_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       remote_lost;
		logic [7:0] motor_lost_mask;
		logic [1:0] chassis_mode;
		logic [1:0] gimbal_mode;
		logic [1:0] cap_mode;
	} word_t;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_CFG_MANUAL,
		ROW_CFG_AUTO
	} row_e;

	// a directed row: a word or a register write, with an optional typed frame
	// in which every pixel has the same color
	typedef struct packed {
		row_e             row;
		word_t            w;
		logic             typed;
		lsfb_pkg::pixel_t px;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} frame_entry_t;

	localparam word_t NO_WORD = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wen = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [7:0] frame_byte;
	logic       frame_last;

	// current input word and its typed expectation, all moved by nba
	word_t            cur_word = '0;
	logic             cur_typed = 1'b0;
	lsfb_pkg::pixel_t cur_px = '0;

	// shadow of the block state
	lsfb_pkg::pixel_t shadow_px [lsfb_pkg::LED_COUNT];
	logic [7:0]       shadow_tick = 8'd0;
	logic             shadow_auto = 1'b1;

	frame_entry_t frame_due [$];
	int           err_count = 0;
	bit           idle_on = 1'b0;
	int           rdy_hold = 0;
	stim_row_t    dir_tab [DIR_ROWS];

	led_status_frame_builder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (cur_word.kind),
		.first_index     (cur_word.first_index),
		.last_index      (cur_word.last_index),
		.red             (cur_word.red),
		.green           (cur_word.green),
		.blue            (cur_word.blue),
		.remote_lost     (cur_word.remote_lost),
		.motor_lost_mask (cur_word.motor_lost_mask),
		.chassis_mode    (cur_word.chassis_mode),
		.gimbal_mode     (cur_word.gimbal_mode),
		.cap_mode        (cur_word.cap_mode),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_byte      (frame_byte),
		.frame_last      (frame_last)
	);

	always #10 clk = ~clk;

	// paint a range of the shadow store, callers keep it inside the store
	task automatic paint(input int lo, input int hi, input lsfb_pkg::pixel_t px);
		int i;
		for (i = lo; i <= hi; i++)
			shadow_px[lsfb_pkg::idx_t'(i)] = px;
	endtask

	// status render on an auto period tick, advances the tick counter
	task automatic render_status(input word_t w);
		int t;
		t = int'(shadow_tick);
		paint(0, lsfb_pkg::LED_COUNT - 1, BLACK);
		if (w.remote_lost) begin
			// alarm blink: whole strip red on even ticks, dark on odd
			if (shadow_tick[0] == 1'b0)
				paint(0, lsfb_pkg::LED_COUNT - 1, ALARM);
		end else begin
			// motor health
			if (w.motor_lost_mask != 8'h00)
				paint(0, 2, '{LVL_MID, LVL_LOW, 8'h00});
			else
				paint(0, 2, '{8'h00, LVL_MID, 8'h00});
			// chassis mode, spin runs a bright marker over pixels 3..5
			case (w.chassis_mode)
				CH_NO_MOVE: paint(3, 5, '{8'h00, 8'h00, LVL_DIM});
				CH_FOLLOW:  paint(3, 5, '{8'h00, LVL_MID, LVL_MID});
				CH_SPIN: begin
					paint(3, 5, '{LVL_LOW, 8'h00, LVL_MID});
					paint(3 + t % 3, 3 + t % 3, '{LVL_HIGH, 8'h00, LVL_HIGH});
				end
				default:    paint(3, 5, '{LVL_MID, LVL_MID, 8'h00});
			endcase
			case (w.gimbal_mode)
				GM_ZERO: paint(6, 6, '{LVL_LOW, 8'h00, 8'h00});
				GM_INIT: paint(6, 6, '{LVL_MID, LVL_MID, 8'h00});
				GM_SPIN: paint(6, 6, '{LVL_LOW, 8'h00, LVL_MID});
				default: paint(6, 6, '{8'h00, LVL_MID, 8'h00});
			endcase
			// capacitor, the unused code reads as charging
			case (w.cap_mode)
				CAP_IN_USE:   paint(7, 7, '{8'h00, 8'h00, LVL_HIGH});
				CAP_PREPARED: paint(7, 7, '{8'h00, LVL_MID, 8'h00});
				default:      paint(7, 7, '{LVL_MID, LVL_LOW, 8'h00});
			endcase
			// heartbeat alternates between pixels 8 and 9
			if (shadow_tick[0] == 1'b0)
				paint(8, 8, '{LVL_LOW, LVL_LOW, LVL_LOW});
			else
				paint(9, 9, '{LVL_LOW, LVL_LOW, LVL_LOW});
		end
		shadow_tick = shadow_tick + 8'd1;
	endtask

	// queue one frame, from the shadow store or from a typed uniform color
	task automatic queue_frame(input logic typed, input lsfb_pkg::pixel_t px);
		int               i;
		lsfb_pkg::pixel_t p;
		frame_due.push_back('{HEAD_A, 1'b0});
		frame_due.push_back('{HEAD_B, 1'b0});
		for (i = 0; i < lsfb_pkg::LED_COUNT; i++) begin
			p = typed ? px : shadow_px[lsfb_pkg::idx_t'(i)];
			frame_due.push_back('{p.red, 1'b0});
			frame_due.push_back('{p.green, 1'b0});
			frame_due.push_back('{p.blue, 1'b0});
		end
		frame_due.push_back('{HEAD_B, 1'b0});
		frame_due.push_back('{HEAD_A, 1'b1});
	endtask

	// update the shadow for one accepted word and queue its frame bytes
	task automatic predict_word(input word_t w, input logic typed,
		input lsfb_pkg::pixel_t px);
		int               hi;
		lsfb_pkg::pixel_t color;
		color = '{w.red, w.green, w.blue};
		case (w.kind)
			lsfb_pkg::KIND_SET: begin
				if (w.first_index < lsfb_pkg::LED_COUNT)
					paint(int'(w.first_index), int'(w.first_index), color);
			end
			lsfb_pkg::KIND_FILL: begin
				// out-of-range start is dropped, the end is clamped
				if (w.first_index < lsfb_pkg::LED_COUNT) begin
					hi = (w.last_index < lsfb_pkg::LED_COUNT) ? int'(w.last_index) :
						lsfb_pkg::LED_COUNT - 1;
					paint(int'(w.first_index), hi, color);
				end
			end
			lsfb_pkg::KIND_CLEAR: paint(0, lsfb_pkg::LED_COUNT - 1, BLACK);
			lsfb_pkg::KIND_TICK: begin
				if (shadow_auto)
					render_status(w);
				queue_frame(typed, px);
			end
			lsfb_pkg::KIND_SEND: queue_frame(typed, px);
			default: ;
		endcase
	endtask

	// input side: register writes and accepted words, sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				shadow_auto = cfg_wdata;
			if (in_valid && in_ready)
				predict_word(cur_word, cur_typed, cur_px);
		end
	end

	// output side: compare each accepted word with the oldest expected byte
	always @(posedge clk) begin : frame_check
		frame_entry_t due;
		if (arst_n && out_valid && out_ready) begin
			if (frame_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected frame word, expected none, actual byte %h last %b",
					$time, frame_byte, frame_last);
			end else begin
				due = frame_due.pop_front();
				if (frame_byte !== due.data) begin
					err_count++;
					$display("%0t: frame_byte mismatch, expected %h, actual %h",
						$time, due.data, frame_byte);
				end
				if (frame_last !== due.is_last) begin
					err_count++;
					$display("%0t: frame_last mismatch, expected %b, actual %b",
						$time, due.is_last, frame_last);
				end
			end
		end
	end

	// receiver stalls in random bursts, only while idling is on
	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold <= rdy_hold - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rdy_hold <= $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// offer one word, with an optional sender gap, and hold it until taken
	task automatic push_word(input word_t w, input logic typed,
		input lsfb_pkg::pixel_t px);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_word <= w;
		cur_typed <= typed;
		cur_px <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop sending, wait for every frame byte, let queued commands finish
	task automatic drain;
		in_valid <= 1'b0;
		// first let the last accepted word be predicted
		@(posedge clk);
		while (frame_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_auto(input logic value);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("** led_status_frame_builder: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int    i;
		int    phase;
		int    sent;
		int    sel;
		word_t w;

		for (i = 0; i < lsfb_pkg::LED_COUNT; i++)
			shadow_px[i] = BLACK;

		// directed part, tick counter starts at zero with auto mode on
		dir_tab = '{
			// send after reset: dark store
			'{ROW_WORD, '{lsfb_pkg::KIND_SEND, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b1, BLACK},
			// remote lost blink: red on even tick, dark on odd tick
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b1, 8'hFF, CH_SPIN, GM_SPIN, CAP_IN_USE}, 1'b1, ALARM},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b1, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b1, BLACK},
			// status renders, spin marker on all three positions
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h80, CH_SPIN, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_FOLLOW, GM_INIT, CAP_PREPARED}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h01, CH_SPIN, GM_SPIN, CAP_IN_USE}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ANGLE, CAP_UNUSED}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'hFF, CH_SPIN, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_RETURN, GM_ANGLE, CAP_IN_USE}, 1'b0, BLACK},
			// manual mode
			'{ROW_CFG_MANUAL, NO_WORD, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SEND, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b1, BLACK},
			// full fill with the end clamped
			'{ROW_WORD, '{lsfb_pkg::KIND_FILL, 8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SEND, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b1, WHITE},
			// manual tick leaves the store alone
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b1, 8'hFF, CH_SPIN, GM_SPIN, CAP_IN_USE}, 1'b1, WHITE},
			// set at the last pixel, then out of range
			'{ROW_WORD, '{lsfb_pkg::KIND_SET, 8'(lsfb_pkg::LED_COUNT - 1), 8'd0,
				8'h01, 8'h02, 8'h03,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SET, 8'(lsfb_pkg::LED_COUNT), 8'd0,
				8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SET, 8'd255, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			// fill with out-of-range start, reversed fill, single pixel fill
			'{ROW_WORD, '{lsfb_pkg::KIND_FILL, 8'(lsfb_pkg::LED_COUNT), 8'd255,
				8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_FILL, 8'd5, 8'd2, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_FILL, 8'd3, 8'd3, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			// unused kinds
			'{ROW_WORD, '{KIND_SPARE5, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{KIND_SPARE6, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{KIND_SPARE7, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SEND, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK},
			// back to auto
			'{ROW_CFG_AUTO, NO_WORD, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_FOLLOW, GM_SPIN, CAP_PREPARED}, 1'b0, BLACK},
			'{ROW_WORD, '{lsfb_pkg::KIND_SEND, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00,
				1'b0, 8'h00, CH_NO_MOVE, GM_ZERO, CAP_CHARGING}, 1'b0, BLACK}
		};

		// reset once, released on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		for (i = 0; i < DIR_ROWS; i++) begin
			case (dir_tab[i].row)
				ROW_CFG_MANUAL: write_auto(1'b0);
				ROW_CFG_AUTO:   write_auto(1'b1);
				default:        push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].px);
			endcase
		end

		// random phases, each after a quiet register write
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				write_auto(1'b0);
			else if (phase == PHASES - 1)
				write_auto(1'b1);
			else
				write_auto(1'($urandom_range(0, 1)));
			// one phase without idling mid-run, none in the last one either
			idle_on = (phase != 3) && (phase != PHASES - 1);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				sel = $urandom_range(0, 99);
				if (sel < 24)
					w.kind = lsfb_pkg::KIND_SET;
				else if (sel < 48)
					w.kind = lsfb_pkg::KIND_FILL;
				else if (sel < 53)
					w.kind = lsfb_pkg::KIND_CLEAR;
				else if (sel < 78)
					w.kind = lsfb_pkg::KIND_TICK;
				else if (sel < 93)
					w.kind = lsfb_pkg::KIND_SEND;
				else
					w.kind = 3'($urandom_range(KIND_SPARE5, KIND_SPARE7));
				// indices mostly near the store, sometimes anywhere
				if ($urandom_range(0, 4) != 0)
					w.first_index = 8'($urandom_range(0, lsfb_pkg::LED_COUNT + 1));
				else
					w.first_index = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 3) != 0)
					w.last_index = 8'($urandom_range(0, lsfb_pkg::LED_COUNT + 1));
				else
					w.last_index = 8'($urandom_range(0, 255));
				w.red = 8'($urandom_range(0, 255));
				w.green = 8'($urandom_range(0, 255));
				w.blue = 8'($urandom_range(0, 255));
				// remote lost kept rare so the full status render dominates
				w.remote_lost = ($urandom_range(0, 4) == 0);
				w.motor_lost_mask = ($urandom_range(0, 1) == 0) ? 8'h00 :
					8'($urandom_range(0, 255));
				w.chassis_mode = 2'($urandom_range(0, 3));
				w.gimbal_mode = 2'($urandom_range(0, 3));
				w.cap_mode = 2'($urandom_range(0, 3));
				push_word(w, 1'b0, BLACK);
				sent++;
			end
		end

		// wait out every expected byte and a tail for stray output
		drain();

		if (err_count == 0 && frame_due.size() == 0)
			$display("** led_status_frame_builder: PASSED **");
		else
			$display("** led_status_frame_builder: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
sv/lsfb_pkg.sv
sv/lsfb_front.sv
sv/lsfb_queue.sv
sv/lsfb_back.sv
sv/led_status_frame_builder.sv
sim/testbench.sv
